// ===== rtl/sfq_pkg.sv =====
package sfq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned REQ_W = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH   = 3'd0,
      REQ_POP    = 3'd1,
      REQ_SEARCH = 3'd2,
      REQ_LENGTH = 3'd3,
      REQ_DUMP   = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

// ===== rtl/sfq_if.sv =====
interface sfq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sfq_pkg::REQ_W-1:0]             req_type;
   logic signed [sfq_pkg::DATA_W-1:0]     data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink (input valid, input req_type, input data_in, output ready);
endinterface

interface sfq_rsp_if #(
   parameter int unsigned CNT_W = sfq_pkg::CNT_W_DEFAULT
);
   logic                                  valid;
   logic                                  ready;
   logic signed [sfq_pkg::DATA_W-1:0]     data_out;
   logic                                  found;
   logic [CNT_W-1:0]                      count;
   logic [sfq_pkg::STATUS_W-1:0]          status;
   logic                                  last;

   modport source (output valid, output data_out, output found, output count,
                   output status, output last, input ready);
   modport sink (input valid, input data_out, input found, input count,
                 input status, input last, output ready);
endinterface

// ===== rtl/searchable_fifo_queue.sv =====
// Channel   Direction  Payload                               Handshake
// req_ch    in         req_type, data_in                     valid / ready
// rsp_ch    out        data_out, found, count, status, last  valid / ready
//
// Push, length query and requests that hit a full or empty queue: the result is
// registered on acceptance and sits in the output register until taken.
// Pop: result from ST_POP. Search: ST_SCAN walks from the head through the single
// registered read port of the ring memory and stops on a match or the last entry.
// Dump: after ST_DUMP, one entry per cycle while rsp_ch.ready stays high.
// Synchronous active-high reset empties the queue; ring contents are not cleared.
// A stalled result holds req_ch.ready low until it transfers.
module searchable_fifo_queue #(
   parameter int unsigned DEPTH = sfq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sfq_req_if.sink     req_ch,
   sfq_rsp_if.source   rsp_ch
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_DUMP,
      ST_STREAM,
      ST_RESP
   } state_type;

   state_type                          state_ff, state_in;
   logic [PTR_W-1:0]                   head_ff, head_in;
   logic [PTR_W-1:0]                   tail_ff, tail_in;
   logic [CNT_W-1:0]                   occ_ff, occ_in;
   logic [PTR_W-1:0]                   ptr_ff, ptr_in;
   logic [CNT_W-1:0]                   left_ff, left_in;
   logic signed [sfq_pkg::DATA_W-1:0]  key_ff, key_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [sfq_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]                   rsp_count_ff, rsp_count_in;
   sfq_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic signed [sfq_pkg::DATA_W-1:0]  entries_ff [DEPTH];
   logic signed [sfq_pkg::DATA_W-1:0]  rd_data_ff;
   logic                               mem_we;

   logic                               full;
   logic                               empty;
   sfq_pkg::req_code_type              req_code;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign full     = (occ_ff == CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign req_code = sfq_pkg::req_code_type'(req_ch.req_type);

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;
   assign rsp_ch.found    = rsp_found_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.last     = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               key_in        = req_ch.data_in;
               rsp_data_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_count_in  = occ_ff;
               rsp_status_in = sfq_pkg::STATUS_OK;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_RESP;
               unique case (req_code)
                  sfq_pkg::REQ_PUSH: begin
                     if (full) begin
                        rsp_status_in = sfq_pkg::STATUS_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        tail_in      = wrap_inc(tail_ff);
                        occ_in       = occ_ff + CNT_W'(1);
                        rsp_count_in = occ_ff + CNT_W'(1);
                     end
                  end
                  sfq_pkg::REQ_POP: begin
                     if (empty) begin
                        rsp_status_in = sfq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = head_ff;
                        state_in     = ST_POP;
                     end
                  end
                  sfq_pkg::REQ_SEARCH: begin
                     if (!empty) begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = head_ff;
                        left_in      = occ_ff;
                        state_in     = ST_SCAN;
                     end
                  end
                  sfq_pkg::REQ_DUMP: begin
                     if (empty) begin
                        rsp_status_in = sfq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = head_ff;
                        left_in      = occ_ff;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     // length query and unused codes keep the defaults
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_data_in  = rd_data_ff;
            rsp_count_in = occ_ff - CNT_W'(1);
            head_in      = wrap_inc(head_ff);
            occ_in       = occ_ff - CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_SCAN: begin
            // rd_data_ff always mirrors the entry at ptr_ff
            if (rd_data_ff == key_ff) begin
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end else if (left_ff == CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               ptr_in  = wrap_inc(ptr_ff);
               left_in = left_ff - CNT_W'(1);
            end
         end
         ST_DUMP: begin
            rsp_data_in  = rd_data_ff;
            rsp_last_in  = (left_ff == CNT_W'(1));
            rsp_valid_in = 1'b1;
            ptr_in       = wrap_inc(ptr_ff);
            left_in      = left_ff - CNT_W'(1);
            state_in     = ST_STREAM;
         end
         ST_STREAM: begin
            if (rsp_ch.ready) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // advance to the next entry on each transfer
                  rsp_data_in = rd_data_ff;
                  rsp_last_in = (left_ff == CNT_W'(1));
                  ptr_in      = wrap_inc(ptr_ff);
                  left_in     = left_ff - CNT_W'(1);
               end
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      key_ff        <= key_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[tail_ff] <= req_ch.data_in;
      end
      rd_data_ff <= entries_ff[ptr_in];
   end

   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (occ_ff == '0 || occ_ff == CNT_W'(DEPTH)))
      else $error("pointers agree but queue neither empty nor full");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while idle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch.ready && rsp_last_ff) |=> (state_ff == ST_IDLE))
      else $error("final result transferred but block not idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_STREAM) |-> $stable(occ_ff))
      else $error("occupancy changed during scan or dump");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

   localparam int unsigned DEPTH = sfq_pkg::DEPTH_DEFAULT;
   localparam int unsigned CNT_W = sfq_pkg::CNT_W_DEFAULT;
   localparam int unsigned REQ_W = sfq_pkg::REQ_W;
   localparam int unsigned DATA_W = sfq_pkg::DATA_W;
   localparam int CLK_PERIOD = 8;
   localparam int RANDOM_ITEMS = 500;
   localparam int LONG_HOLD = 150;
   localparam int DRAIN_CYCLES = DEPTH + 10;
   localparam int TIMEOUT_CYCLES = 400000;

   // request codes the block treats as a length query
   localparam logic [REQ_W-1:0] REQ_SPARE0 = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE1 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE2 = 3'd7;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [REQ_W-1:0]          code;
      logic signed [DATA_W-1:0]  value;
   } queue_req_type;

   typedef struct {
      logic signed [DATA_W-1:0]  data;
      logic                      found;
      logic [CNT_W-1:0]          count;
      sfq_pkg::status_type       status;
      logic                      last;
   } queue_rsp_type;

   logic clock;
   logic reset;

   sfq_req_if                     req_ch ();
   sfq_rsp_if #(.CNT_W(CNT_W))    rsp_ch ();

   searchable_fifo_queue #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Queue predictor: ring contents, pointers and occupancy
   // ---------------------------------------------------------------
   logic signed [DATA_W-1:0] ring_mem [DEPTH];
   int                       head_idx = 0;
   int                       tail_idx = 0;
   int                       fill_level = 0;
   queue_rsp_type            fifo_results [$];

   int full_drops = 0;
   int empty_rejects = 0;
   int search_hits = 0;
   int longest_dump = 0;

   function automatic void note_result(logic signed [DATA_W-1:0] data, logic hit,
                                       sfq_pkg::status_type st, logic fin);
      queue_rsp_type r;
      r.data   = data;
      r.found  = hit;
      r.count  = CNT_W'(fill_level);
      r.status = st;
      r.last   = fin;
      fifo_results.push_back(r);
   endfunction

   task automatic apply_request(input logic [REQ_W-1:0] code,
                                input logic signed [DATA_W-1:0] value);
      int                       idx;
      logic                     hit;
      logic signed [DATA_W-1:0] popped;
      if (code == sfq_pkg::REQ_PUSH) begin
         if (fill_level >= DEPTH) begin
            full_drops++;
            note_result('0, 1'b0, sfq_pkg::STATUS_FULL, 1'b1);
         end else begin
            ring_mem[tail_idx] = value;
            tail_idx = (tail_idx + 1) % DEPTH;
            fill_level++;
            note_result('0, 1'b0, sfq_pkg::STATUS_OK, 1'b1);
         end
      end else if (code == sfq_pkg::REQ_POP) begin
         if (fill_level == 0) begin
            empty_rejects++;
            note_result('0, 1'b0, sfq_pkg::STATUS_EMPTY, 1'b1);
         end else begin
            popped = ring_mem[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
            fill_level--;
            note_result(popped, 1'b0, sfq_pkg::STATUS_OK, 1'b1);
         end
      end else if (code == sfq_pkg::REQ_SEARCH) begin
         hit = 1'b0;
         idx = head_idx;
         for (int i = 0; i < fill_level; i++) begin
            if (ring_mem[idx] == value) hit = 1'b1;
            idx = (idx + 1) % DEPTH;
         end
         if (hit) search_hits++;
         note_result('0, hit, sfq_pkg::STATUS_OK, 1'b1);
      end else if (code == sfq_pkg::REQ_DUMP) begin
         if (fill_level == 0) begin
            empty_rejects++;
            note_result('0, 1'b0, sfq_pkg::STATUS_EMPTY, 1'b1);
         end else begin
            idx = head_idx;
            for (int i = 0; i < fill_level; i++) begin
               note_result(ring_mem[idx], 1'b0, sfq_pkg::STATUS_OK, i == fill_level - 1);
               idx = (idx + 1) % DEPTH;
            end
            if (fill_level > longest_dump) longest_dump = fill_level;
         end
      end else begin
         note_result('0, 1'b0, sfq_pkg::STATUS_OK, 1'b1);
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: predict on each request transfer, check each result transfer
   // ---------------------------------------------------------------
   int            req_accepted = 0;
   int            rsp_accepted = 0;
   int            mismatches = 0;
   queue_rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            apply_request(req_ch.req_type, req_ch.data_in);
            req_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_accepted++;
            if (fifo_results.size() == 0) begin
               $error("result with nothing expected: data_out %0d count %0d status %0d",
                      rsp_ch.data_out, rsp_ch.count, rsp_ch.status);
               mismatches++;
            end else begin
               want = fifo_results.pop_front();
               if (rsp_ch.data_out !== want.data) begin
                  $error("data_out: expected %0d, actual %0d", want.data, rsp_ch.data_out);
                  mismatches++;
               end
               if (rsp_ch.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                  mismatches++;
               end
               if (rsp_ch.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                  mismatches++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  mismatches++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                  mismatches++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver, receiver and long hold-off
   // ---------------------------------------------------------------
   queue_req_type req_backlog [$];
   int            total_items = 0;
   int            launched = 0;
   int            idle_phase;
   int            hold_left;
   logic          hold_done;
   queue_req_type next_req;

   function automatic int sender_idle_pct(int phase);
      return (phase == 0) ? 31 : (phase == 1) ? 61 : 0;
   endfunction

   function automatic int receiver_idle_pct(int phase);
      return (phase == 0) ? 61 : (phase == 1) ? 31 : 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         idle_phase <= 0;
      end else begin
         if (!req_ch.valid || req_ch.ready) begin
            if (req_backlog.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(idle_phase)) begin
               next_req = req_backlog.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= next_req.code;
               req_ch.data_in  <= next_req.value;
               launched++;
            end else begin
               req_ch.valid   <= 1'b0;
               req_ch.data_in <= $urandom;
            end
         end
         idle_phase <= (launched * 3 / total_items > 2) ? 2 : launched * 3 / total_items;
      end
   end

   // once the idle-free phase starts, block results long enough to back up the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && idle_phase == 2) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) &&
                         ($urandom_range(99) >= receiver_idle_pct(idle_phase));
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic signed [DATA_W-1:0] recent_values [$];

   task automatic queue_req(input logic [REQ_W-1:0] code,
                            input logic signed [DATA_W-1:0] value);
      queue_req_type r;
      r.code  = code;
      r.value = value;
      req_backlog.push_back(r);
      if (code == sfq_pkg::REQ_PUSH) begin
         recent_values.push_back(value);
         if (recent_values.size() > 32) void'(recent_values.pop_front());
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return int'($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_key();
      if (recent_values.size() != 0 && $urandom_range(2) != 0)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      return pick_value();
   endfunction

   initial begin
      int directed_items;
      req_ch.valid    = 1'b0;
      req_ch.req_type = sfq_pkg::REQ_LENGTH;
      req_ch.data_in  = '0;
      rsp_ch.ready    = 1'b0;
      reset           = 1'b1;

      // empty-queue corners, value extremes, hit and miss, spare codes
      queue_req(sfq_pkg::REQ_LENGTH, $urandom);
      queue_req(sfq_pkg::REQ_POP, $urandom);
      queue_req(sfq_pkg::REQ_DUMP, $urandom);
      queue_req(sfq_pkg::REQ_SEARCH, 0);
      queue_req(sfq_pkg::REQ_PUSH, VALUE_MIN);
      queue_req(sfq_pkg::REQ_PUSH, VALUE_MAX);
      queue_req(sfq_pkg::REQ_PUSH, -1);
      queue_req(sfq_pkg::REQ_PUSH, 0);
      queue_req(sfq_pkg::REQ_SEARCH, VALUE_MAX);
      queue_req(sfq_pkg::REQ_SEARCH, 0);
      queue_req(sfq_pkg::REQ_SEARCH, 1);
      queue_req(sfq_pkg::REQ_DUMP, -1);
      queue_req(REQ_SPARE0, $urandom);
      queue_req(REQ_SPARE1, $urandom);
      queue_req(REQ_SPARE2, $urandom);
      queue_req(sfq_pkg::REQ_POP, $urandom);
      queue_req(sfq_pkg::REQ_POP, $urandom);
      directed_items = req_backlog.size();

      while (req_backlog.size() < directed_items + RANDOM_ITEMS) begin
         case ($urandom_range(3))
            0, 1: begin
               // fill (sometimes past full), inspect, then drain (sometimes past empty)
               repeat ($urandom_range(1, DEPTH + 3)) begin
                  queue_req(sfq_pkg::REQ_PUSH, pick_value());
                  if ($urandom_range(5) == 0) queue_req(sfq_pkg::REQ_SEARCH, pick_key());
               end
               queue_req(sfq_pkg::REQ_DUMP, $urandom);
               queue_req(sfq_pkg::REQ_SEARCH, pick_key());
               repeat ($urandom_range(1, DEPTH + 2)) queue_req(sfq_pkg::REQ_POP, $urandom);
               queue_req(sfq_pkg::REQ_LENGTH, $urandom);
            end
            2: begin
               repeat ($urandom_range(1, 6)) begin
                  queue_req(sfq_pkg::REQ_PUSH, pick_value());
                  queue_req($urandom_range(1) ? sfq_pkg::REQ_POP : sfq_pkg::REQ_SEARCH,
                            pick_key());
               end
            end
            default: begin
               repeat ($urandom_range(1, 8))
                  queue_req(REQ_W'($urandom_range(7)), pick_value());
            end
         endcase
      end
      total_items = req_backlog.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted < total_items) @(posedge clock);
      while (fifo_results.size() != 0) @(posedge clock);
      // catch any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run sent %0d requests and checked %0d results, longest dump %0d entries.",
               req_accepted, rsp_accepted, longest_dump);
      $display("Pushes dropped on full: %0d, pops or dumps on empty: %0d, search hits: %0d.",
               full_drops, empty_rejects, search_hits);
      if (mismatches == 0 && fifo_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d results still expected.", fifo_results.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
